// ===== src/vgvg_pkg.sv =====
// Package for the vector glyph vertex generator: font tables, constants,
// the divide-by-255 helper and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package vgvg_pkg;

    // Parameter defaults
    localparam int MAX_CHARS_DEF        = 64;
    localparam int MAX_GLYPH_POINTS_DEF = 14;

    // Font geometry
    localparam int GLYPH_COUNT = 12;
    localparam int TABLE_PTS   = 14;
    localparam int PT_MAX_W    = 5;

    localparam logic [7:0] KERN_UNITS  = 8'd50;
    localparam logic [7:0] DIGIT_WIDTH = 8'd178;
    localparam logic [7:0] DOT_WIDTH   = 8'd50;

    localparam logic [3:0] COLON_IDX  = 4'd10;
    localparam logic [3:0] PERIOD_IDX = 4'd11;

    localparam logic [7:0] CODE_NUL    = 8'h00;
    localparam logic [7:0] CODE_ZERO   = 8'h30;
    localparam logic [7:0] CODE_NINE   = 8'h39;
    localparam logic [7:0] CODE_COLON  = 8'h3A;
    localparam logic [7:0] CODE_PERIOD = 8'h2E;

    // Multiplier operand selection
    localparam logic [1:0] SEL_POINT = 2'd0;
    localparam logic [1:0] SEL_KERN  = 2'd1;
    localparam logic [1:0] SEL_ADV   = 2'd2;

    localparam logic [7:0] PT_X [GLYPH_COUNT][TABLE_PTS] = '{
        '{8'd0, 8'd178, 8'd178, 8'd0, 8'd0, 8'd50, 8'd50, 8'd128, 8'd128, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd114, 8'd114, 8'd178, 8'd178, 8'd0, 8'd0, 8'd64, 8'd64, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd178, 8'd178, 8'd50, 8'd50, 8'd178, 8'd178, 8'd0, 8'd0,
          8'd128, 8'd128, 8'd50, 8'd50},
        '{8'd0, 8'd178, 8'd178, 8'd0, 8'd0, 8'd128, 8'd128, 8'd26, 8'd26, 8'd128,
          8'd128, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd128, 8'd128, 8'd178, 8'd178, 8'd128, 8'd128, 8'd50, 8'd50,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd178, 8'd0, 8'd0, 8'd128, 8'd128, 8'd50, 8'd50, 8'd0, 8'd0, 8'd178,
          8'd178, 8'd50, 8'd50, 8'd178},
        '{8'd178, 8'd0, 8'd0, 8'd178, 8'd178, 8'd25, 8'd25, 8'd128, 8'd128, 8'd50,
          8'd50, 8'd178, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd178, 8'd178, 8'd128, 8'd128, 8'd50, 8'd50, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd178, 8'd178, 8'd0, 8'd0, 8'd163, 8'd163, 8'd50, 8'd50,
          8'd128, 8'd128, 8'd50, 8'd50},
        '{8'd0, 8'd178, 8'd178, 8'd0, 8'd0, 8'd163, 8'd163, 8'd50, 8'd50, 8'd128,
          8'd128, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd50, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd50, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0}
    };

    localparam logic [7:0] PT_Y [GLYPH_COUNT][TABLE_PTS] = '{
        '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd205, 8'd205, 8'd50, 8'd50,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd205, 8'd205, 8'd255, 8'd255, 8'd205, 8'd205, 8'd50, 8'd50,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd68, 8'd0, 8'd0, 8'd153, 8'd153, 8'd205, 8'd205, 8'd255, 8'd255, 8'd103,
          8'd103, 8'd50, 8'd50, 8'd68},
        '{8'd0, 8'd0, 8'd255, 8'd255, 8'd205, 8'd205, 8'd153, 8'd153, 8'd103, 8'd103,
          8'd50, 8'd50, 8'd0, 8'd0},
        '{8'd0, 8'd153, 8'd153, 8'd255, 8'd255, 8'd0, 8'd0, 8'd103, 8'd103, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd0, 8'd0, 8'd153, 8'd153, 8'd205, 8'd205, 8'd187, 8'd187, 8'd255, 8'd255,
          8'd103, 8'd103, 8'd50, 8'd50},
        '{8'd0, 8'd0, 8'd255, 8'd255, 8'd103, 8'd103, 8'd153, 8'd153, 8'd205, 8'd205,
          8'd50, 8'd50, 8'd0, 8'd0},
        '{8'd76, 8'd0, 8'd0, 8'd255, 8'd255, 8'd50, 8'd50, 8'd76, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd153, 8'd0, 8'd0, 8'd255, 8'd255, 8'd103, 8'd103, 8'd153, 8'd153, 8'd205,
          8'd205, 8'd50, 8'd50, 8'd153},
        '{8'd255, 8'd255, 8'd0, 8'd0, 8'd153, 8'd153, 8'd103, 8'd103, 8'd50, 8'd50,
          8'd205, 8'd205, 8'd0, 8'd0},
        '{8'd50, 8'd50, 8'd100, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd205, 8'd205, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0}
    };

    localparam logic [4:0] NPTS [GLYPH_COUNT] = '{
        5'd10, 5'd10, 5'd14, 5'd12, 5'd10, 5'd14, 5'd12, 5'd8, 5'd14, 5'd12, 5'd4, 5'd4
    };

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       kern_update;
        logic       adv_update;
        logic       emit;
        logic       pt_next;
        logic       poly_period;
    } vgvg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_first;
        logic draw_ok;
        logic pt_last;
        logic poly_more;
        logic out_free;
    } vgvg_stat_t;

    // Map a character byte to a glyph index; bit 4 is the hit flag
    function automatic logic [4:0] glyph_lookup(input logic [7:0] code);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (code >= CODE_ZERO && code <= CODE_COLON)
            begin
                r = {1'b1, 4'(code - CODE_ZERO)};
            end
            else if (code == CODE_PERIOD)
            begin
                r = {1'b1, PERIOD_IDX};
            end
            return r;
        end
    endfunction

    function automatic logic [7:0] point_x(input logic [3:0] g, input logic [4:0] p);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (g < 4'(GLYPH_COUNT) && p < 5'(TABLE_PTS))
            begin
                v = PT_X[g][p[3:0]];
            end
            return v;
        end
    endfunction

    function automatic logic [7:0] point_y(input logic [3:0] g, input logic [4:0] p);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (g < 4'(GLYPH_COUNT) && p < 5'(TABLE_PTS))
            begin
                v = PT_Y[g][p[3:0]];
            end
            return v;
        end
    endfunction

    function automatic logic [4:0] glyph_npts(input logic [3:0] g);
        logic [4:0] v;
        begin
            v = 5'd0;
            if (g < 4'(GLYPH_COUNT))
            begin
                v = NPTS[g];
            end
            return v;
        end
    endfunction

    function automatic logic [7:0] glyph_width(input logic [3:0] g);
        logic [7:0] v;
        begin
            v = DIGIT_WIDTH;
            if (g == COLON_IDX || g == PERIOD_IDX)
            begin
                v = DOT_WIDTH;
            end
            return v;
        end
    endfunction

    // Exact floor(p/255) for p below 2^20: (p+1) * 0x10101 >> 24, done with adds
    function automatic logic [12:0] div255(input logic [19:0] p);
        logic [36:0] y;
        logic [36:0] s;
        begin
            y = 37'(p) + 37'd1;
            s = (y << 16) + (y << 8) + y;
            return s[36:24];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/vgvg_datapath.sv =====
// Datapath of the vector glyph vertex generator: string state, glyph cursor,
// two scaling lanes (multiply, then divide by 255) and the result register.
// Depends on vgvg_pkg.
`default_nettype none

module vgvg_datapath
    import vgvg_pkg::*;
#(
    parameter int MAX_CHARS        = MAX_CHARS_DEF,
    parameter int MAX_GLYPH_POINTS = MAX_GLYPH_POINTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  code,
    input  wire logic        first,
    input  wire logic [11:0] char_size,
    input  wire logic [15:0] origin_x,
    input  wire logic [15:0] origin_y,
    input  wire vgvg_cmd_t   cmd,
    output vgvg_stat_t       stat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      vertex_x,
    output logic [15:0]      vertex_y,
    output logic             polygon_end,
    output logic             last
);

    localparam int PT_W = $clog2(MAX_GLYPH_POINTS);

    // String state
    logic [15:0] pen_reg;
    logic [15:0] base_reg;
    logic [11:0] scale_reg;
    logic [6:0]  count_reg;
    logic        stopped_reg;

    // Glyph cursor
    logic [3:0]      glyph_reg;
    logic [3:0]      poly_reg;
    logic [PT_W-1:0] pt_reg;

    // Lane products
    logic [19:0] prod_x_reg;
    logic [19:0] prod_y_reg;

    // Result register
    logic        out_valid_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic        out_pend_reg;
    logic        out_last_reg;

    logic [4:0]  hit;
    logic        stop_eff;
    logic [6:0]  cnt_eff;
    logic [6:0]  cnt_inc;
    logic [4:0]  pt_ext;
    logic [4:0]  npts_eff;
    logic [7:0]  ux;
    logic [7:0]  uy;
    logic [12:0] sx;
    logic [12:0] sy;

    // Decode the request as the string state will see it
    always_comb
    begin
        hit      = glyph_lookup(code);
        stop_eff = first ? 1'b0 : stopped_reg;
        cnt_eff  = first ? 7'd0 : count_reg;
        cnt_inc  = cnt_eff + 7'd1;
    end

    // Glyph cursor position and clamped point count
    always_comb
    begin
        pt_ext   = 5'(pt_reg);
        npts_eff = glyph_npts(poly_reg);
        if (6'(npts_eff) > 6'(MAX_GLYPH_POINTS))
        begin
            npts_eff = 5'(MAX_GLYPH_POINTS);
        end
    end

    // Select multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            SEL_POINT:
            begin
                ux = point_x(poly_reg, pt_ext);
                uy = point_y(poly_reg, pt_ext);
            end
            SEL_KERN:
            begin
                ux = KERN_UNITS;
                uy = 8'd0;
            end
            SEL_ADV:
            begin
                ux = glyph_width(glyph_reg) + KERN_UNITS;
                uy = 8'd0;
            end
            default:
            begin
                ux = 8'd0;
                uy = 8'd0;
            end
        endcase
    end

    assign sx = div255(prod_x_reg);
    assign sy = div255(prod_y_reg);

    // Status to the controller
    always_comb
    begin
        stat.in_first  = first;
        stat.draw_ok   = !stop_eff && (code != CODE_NUL) && hit[4];
        stat.pt_last   = (pt_ext == npts_eff - 5'd1);
        stat.poly_more = (poly_reg == COLON_IDX);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // Hold string state; latch a new string on its first request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg     <= 16'd0;
            base_reg    <= 16'd0;
            scale_reg   <= 12'd0;
            count_reg   <= 7'd0;
            stopped_reg <= 1'b1;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (first)
                begin
                    scale_reg <= char_size;
                    base_reg  <= origin_y;
                    pen_reg   <= origin_x;
                end
                if (stop_eff)
                begin
                    count_reg   <= cnt_eff;
                    stopped_reg <= 1'b1;
                end
                else if (code == CODE_NUL)
                begin
                    count_reg   <= cnt_eff;
                    stopped_reg <= 1'b1;
                end
                else
                begin
                    count_reg   <= cnt_inc;
                    stopped_reg <= (cnt_inc >= 7'(MAX_CHARS));
                end
            end
            else if (cmd.kern_update)
            begin
                pen_reg <= pen_reg + 16'(sx >> 1);
            end
            else if (cmd.adv_update)
            begin
                pen_reg <= pen_reg + 16'(sx);
            end
        end
    end

    // Advance the glyph cursor
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            glyph_reg <= hit[3:0];
            poly_reg  <= hit[3:0];
            pt_reg    <= '0;
        end
        else if (cmd.poly_period)
        begin
            poly_reg <= PERIOD_IDX;
            pt_reg   <= '0;
        end
        else if (cmd.pt_next)
        begin
            pt_reg <= pt_reg + PT_W'(1);
        end
    end

    // Scaling multipliers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_x_reg <= 20'(ux) * 20'(scale_reg);
            prod_y_reg <= 20'(uy) * 20'(scale_reg);
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Offset the scaled vertex into the result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x_reg    <= pen_reg + 16'(sx);
            out_y_reg    <= base_reg + 16'(sy);
            out_pend_reg <= stat.pt_last;
            out_last_reg <= stat.pt_last && !stat.poly_more;
        end
    end

    assign out_valid   = out_valid_reg;
    assign vertex_x    = out_x_reg;
    assign vertex_y    = out_y_reg;
    assign polygon_end = out_pend_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire

// ===== src/vgvg_ctrl.sv =====
// Controller of the vector glyph vertex generator: sequences kerning, vertex
// and pen-advance steps over the datapath. Depends on vgvg_pkg.
`default_nettype none

module vgvg_ctrl
    import vgvg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire vgvg_stat_t stat,
    output vgvg_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KMUL = 3'd1;
    localparam logic [2:0] ST_KDIV = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_AMUL = 3'd5;
    localparam logic [2:0] ST_ADIV = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       draw_reg;
    logic       draw_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        draw_next  = draw_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    draw_next  = stat.draw_ok;
                    if (stat.in_first)
                    begin
                        state_next = ST_KMUL;
                    end
                    else if (stat.draw_ok)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_KMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_KERN;
                state_next  = ST_KDIV;
            end
            ST_KDIV:
            begin
                cmd.kern_update = 1'b1;
                state_next      = draw_reg ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_POINT;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                // Hold the vertex until the result register frees up
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!stat.pt_last)
                    begin
                        cmd.pt_next = 1'b1;
                        state_next  = ST_MUL;
                    end
                    else if (stat.poly_more)
                    begin
                        cmd.poly_period = 1'b1;
                        state_next      = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_AMUL;
                    end
                end
            end
            ST_AMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_ADV;
                state_next  = ST_ADIV;
            end
            ST_ADIV:
            begin
                cmd.adv_update = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            draw_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            draw_reg  <= draw_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/vector_glyph_vertex_generator_top.sv =====
// Vector glyph vertex generator, top level. A request with a glyph of n vertices
// (n up to 14; a colon gives 8) is accepted, kerned if first is set, then runs a
// multiply and a divide step per vertex and a multiply and an advance step for the
// pen before the next ready; a vertex waiting on m_tready stalls it. Requests that
// emit nothing take only the accept (and the kerning with first set). Reset is
// asynchronous, active low; the string stays stopped until a first request.
`default_nettype none

module vector_glyph_vertex_generator_top
    import vgvg_pkg::*;
#(
    parameter int MAX_CHARS        = MAX_CHARS_DEF,
    parameter int MAX_GLYPH_POINTS = MAX_GLYPH_POINTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // code[7:0], char_size[19:8], origin_x[35:20],
                                       // origin_y[51:36], zero[55:52]
    input  wire logic [0:0]  s_tuser,  // first[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // vertex_x[15:0], vertex_y[31:16]
    output logic [0:0]       m_tuser,  // polygon_end[0]
    output logic             m_tlast   // last result of the request
);

    vgvg_cmd_t   cmd;
    vgvg_stat_t  stat;
    logic [15:0] vertex_x;
    logic [15:0] vertex_y;
    logic        polygon_end;
    logic        last;

    vgvg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vgvg_datapath #(
        .MAX_CHARS        (MAX_CHARS),
        .MAX_GLYPH_POINTS (MAX_GLYPH_POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .code        (s_tdata[7:0]),
        .first       (s_tuser[0]),
        .char_size   (s_tdata[19:8]),
        .origin_x    (s_tdata[35:20]),
        .origin_y    (s_tdata[51:36]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .polygon_end (polygon_end),
        .last        (last)
    );

    assign m_tdata = {vertex_y, vertex_x};
    assign m_tuser = polygon_end;
    assign m_tlast = last;

    // The last result of a request always closes a polygon
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("last result without polygon end");

    // A vertex is only loaded when the result register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("vertex loaded over an untaken result");

    // Every multiply is followed by its divide step, never by another multiply
    a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_en |=> !cmd.mul_en && !cmd.accept)
        else $error("multiply not followed by divide step");

endmodule

`default_nettype wire
